[hw/rtl/assert_macros.svh]
// Assertion macros, clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CBE_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error("lbl");
`define CBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("lbl");
`else
`define CBE_ASSERT_ALWAYS(lbl, expr)
`define CBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/cbe_pkg.sv]
`default_nettype none
package cbe_pkg;
    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 32;
    localparam int GUESS_W   = FRAC_BITS + 2;
    localparam int TIME_W    = FRAC_BITS + 1;
    localparam int OUT_W     = FRAC_BITS + 3;
    localparam int CFG_W     = FRAC_BITS + 2;
    localparam int NUM_W     = ACC_W + FRAC_BITS;
    localparam int QDIV_W    = FRAC_BITS + 6;
    localparam int MUL_W     = ACC_W + GUESS_W;

    localparam logic signed [ACC_W-1:0] ONE_Q     = ACC_W'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] OUT_MAX   = (ACC_W'(4) <<< FRAC_BITS) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_MIN   = -(ACC_W'(4) <<< FRAC_BITS);

    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [GUESS_W-1:0] guess_t;

    typedef enum logic [1:0] {
        CFG_CTRL1_X = 2'd0,
        CFG_CTRL1_Y = 2'd1,
        CFG_CTRL2_X = 2'd2,
        CFG_CTRL2_Y = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic start;
        logic [NUM_W-1:0] num_mag;
        logic [ACC_W-1:0] den_mag;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [QDIV_W-1:0] quot;
    } div_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/cbe_stream_if.sv]
`default_nettype none
interface cbe_time_if import cbe_pkg::*;;
    logic valid;
    logic ready;
    logic [TIME_W-1:0] time_in;
    modport source (output valid, output time_in, input ready);
    modport sink (input valid, input time_in, output ready);
endinterface

interface cbe_ease_if import cbe_pkg::*;;
    logic valid;
    logic ready;
    logic signed [OUT_W-1:0] eased_value;
    modport source (output valid, output eased_value, input ready);
    modport sink (input valid, input eased_value, output ready);
endinterface
`default_nettype wire

[hw/rtl/cbe_mulq.sv]
`default_nettype none
// Fixed product with rounding half away from zero, then an add.
module cbe_mulq
    import cbe_pkg::*;
(
    input  wire acc_t   a,
    input  wire guess_t b,
    input  wire acc_t   addend,
    output acc_t        res
);
    logic signed [MUL_W-1:0] prod;
    logic [MUL_W-1:0] prod_mag;
    logic [MUL_W-1:0] rnd;
    logic [ACC_W-1:0] rnd_s;
    acc_t rq;

    always_comb
    begin
        prod     = MUL_W'(a) * MUL_W'(b);
        prod_mag = prod[MUL_W-1] ? MUL_W'(-prod) : MUL_W'(prod);
        rnd      = (prod_mag + (MUL_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        rnd_s    = rnd[ACC_W-1:0];
        rq       = prod[MUL_W-1] ? acc_t'(-rnd_s) : acc_t'(rnd_s);
        res      = rq + addend;
    end
endmodule
`default_nettype wire

[hw/rtl/cbe_div.sv]
`default_nettype none
// Restoring divider, one quotient bit a cycle, top bit flags a large quotient.
module cbe_div
    import cbe_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire div_req_t req,
    output div_rsp_t  rsp
);
    localparam int DSH_W = ACC_W + QDIV_W - 1;
    localparam int CNT_W = $clog2(QDIV_W);

    logic busy_reg;
    logic done_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QDIV_W-1:0] q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic fits;

    assign fits = {{(DSH_W-NUM_W){1'b0}}, rem_reg} >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= req.num_mag;
                dsh_reg  <= {req.den_mag, {(QDIV_W-1){1'b0}}};
                q_reg    <= '0;
                cnt_reg  <= CNT_W'(QDIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg[NUM_W-1:0];
                end
                q_reg   <= {q_reg[QDIV_W-2:0], fits};
                dsh_reg <= dsh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
endmodule
`default_nettype wire

[hw/rtl/cubic_bezier_easing.sv]
// channel   dir   payload                     request moved when
// in_ch     in    time_in      u17 Q1.16      valid & ready
// out_ch    out   eased_value  s19 Q3.16      valid & ready
// cfg       in    cfg_index, cfg_data (18b)   cfg_we
// Linear curve: time_in goes straight to the output. Otherwise each Newton step runs
// the multiply/control states and the serial divider, then y is computed after
// NEWTON_STEPS steps, or earlier when the slope reaches zero.
// Reset loads the default control points; no clearing pass.
// A held result does not block a new request; finishing waits for out_ch.
`default_nettype none
`include "assert_macros.svh"
module cubic_bezier_easing
    import cbe_pkg::*;
#(
    parameter int NEWTON_STEPS = 32
)
(
    input  wire              clk,
    input  wire              rst_n,
    cbe_time_if.sink         in_ch,
    cbe_ease_if.source       out_ch,
    input  wire              cfg_we,
    input  wire cfg_idx_t    cfg_index,
    input  wire [CFG_W-1:0]  cfg_data
);
    localparam int STEP_W = $clog2(NEWTON_STEPS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SL0, ST_SL1, ST_SL2, ST_CHK, ST_CV0, ST_CV1, ST_CV2,
        ST_DIV, ST_DIVW, ST_UPD, ST_YC0, ST_YC1, ST_YC2, ST_OUT
    } state_t;

    state_t state_reg;
    logic [TIME_W-1:0] c1x_reg, c2x_reg, t_reg;
    logic [CFG_W-1:0]  c1y_reg, c2y_reg;
    acc_t acc_reg, slope_reg, err_reg;
    guess_t guess_reg;
    logic [STEP_W-1:0] step_reg;
    logic signed [OUT_W-1:0] res_reg;
    logic out_valid_reg;
    logic signed [OUT_W-1:0] out_data_reg;

    acc_t c1x, c2x, c1y, c2y, ax, bx, cx, ay, by, cy, ax3, bx2;
    acc_t mul_a, mul_add, mres;
    logic linear;
    div_req_t dreq;
    div_rsp_t drsp;
    logic q_neg;
    logic signed [QDIV_W+2:0] qs, gsum;
    guess_t gnew;
    logic out_free;

    always_comb
    begin
        c1x = acc_t'({1'b0, c1x_reg});
        c2x = acc_t'({1'b0, c2x_reg});
        c1y = acc_t'(signed'(c1y_reg));
        c2y = acc_t'(signed'(c2y_reg));
        ax  = ONE_Q - 3 * c2x + 3 * c1x;
        bx  = 3 * c2x - 6 * c1x;
        cx  = 3 * c1x;
        ay  = ONE_Q - 3 * c2y + 3 * c1y;
        by  = 3 * c2y - 6 * c1y;
        cy  = 3 * c1y;
        ax3 = 3 * ax;
        bx2 = 2 * bx;
        linear = ({1'b0, c1x_reg} == c1y_reg) && ({1'b0, c2x_reg} == c2y_reg);
    end

    always_comb
    begin
        mul_a   = '0;
        mul_add = '0;
        unique case (state_reg)
            ST_SL0: mul_a = ax3;
            ST_SL1: mul_a = acc_reg;
            ST_SL2:
            begin
                mul_a   = bx2;
                mul_add = slope_reg + cx;
            end
            ST_CV0:
            begin
                mul_a   = ax;
                mul_add = bx;
            end
            ST_CV1:
            begin
                mul_a   = acc_reg;
                mul_add = cx;
            end
            ST_CV2: mul_a = acc_reg;
            ST_YC0:
            begin
                mul_a   = ay;
                mul_add = by;
            end
            ST_YC1:
            begin
                mul_a   = acc_reg;
                mul_add = cy;
            end
            ST_YC2: mul_a = acc_reg;
            default:
            begin
                mul_a   = '0;
                mul_add = '0;
            end
        endcase
    end

    cbe_mulq u_mulq (
        .a      (mul_a),
        .b      (guess_reg),
        .addend (mul_add),
        .res    (mres)
    );

    always_comb
    begin
        dreq.start   = (state_reg == ST_DIV);
        dreq.num_mag = NUM_W'(err_reg[ACC_W-1] ? -err_reg : err_reg) << FRAC_BITS;
        dreq.den_mag = slope_reg[ACC_W-1] ? ACC_W'(-slope_reg) : ACC_W'(slope_reg);
    end

    cbe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        q_neg = err_reg[ACC_W-1] ^ slope_reg[ACC_W-1];
        qs    = q_neg ? -$signed({3'b000, drsp.quot}) : $signed({3'b000, drsp.quot});
        gsum  = (QDIV_W+3)'(guess_reg) - qs;
        if (gsum > (QDIV_W+3)'(signed'({1'b0, {(GUESS_W-1){1'b1}}})))
            gnew = {1'b0, {(GUESS_W-1){1'b1}}};
        else if (gsum < (QDIV_W+3)'(signed'({1'b1, {(GUESS_W-1){1'b0}}})))
            gnew = {1'b1, {(GUESS_W-1){1'b0}}};
        else
            gnew = gsum[GUESS_W-1:0];
    end

    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            c1x_reg       <= TIME_W'(16384);
            c1y_reg       <= CFG_W'(16384);
            c2x_reg       <= TIME_W'(49152);
            c2y_reg       <= CFG_W'(49152);
            step_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CTRL1_X: c1x_reg <= cfg_data[TIME_W-1:0];
                    CFG_CTRL1_Y: c1y_reg <= cfg_data;
                    CFG_CTRL2_X: c2x_reg <= cfg_data[TIME_W-1:0];
                    CFG_CTRL2_Y: c2y_reg <= cfg_data;
                endcase
            end
            // in ST_OUT the held result is replaced or kept below
            if (out_valid_reg && out_ch.ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        t_reg     <= in_ch.time_in;
                        guess_reg <= GUESS_W'(in_ch.time_in);
                        res_reg   <= OUT_W'(in_ch.time_in);
                        step_reg  <= '0;
                        state_reg <= linear ? ST_OUT : ST_SL0;
                    end
                end
                ST_SL0:
                begin
                    acc_reg   <= mres;
                    state_reg <= ST_SL1;
                end
                ST_SL1:
                begin
                    slope_reg <= mres;
                    state_reg <= ST_SL2;
                end
                ST_SL2:
                begin
                    slope_reg <= mres;
                    state_reg <= ST_CHK;
                end
                ST_CHK: state_reg <= (slope_reg == '0) ? ST_YC0 : ST_CV0;
                ST_CV0:
                begin
                    acc_reg   <= mres;
                    state_reg <= ST_CV1;
                end
                ST_CV1:
                begin
                    acc_reg   <= mres;
                    state_reg <= ST_CV2;
                end
                ST_CV2:
                begin
                    err_reg   <= mres - acc_t'({1'b0, t_reg});
                    state_reg <= ST_DIV;
                end
                ST_DIV: state_reg <= ST_DIVW;
                ST_DIVW:
                begin
                    if (drsp.done)
                        state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    guess_reg <= gnew;
                    step_reg  <= step_reg + STEP_W'(1);
                    state_reg <= (step_reg == STEP_W'(NEWTON_STEPS - 1)) ? ST_YC0 : ST_SL0;
                end
                ST_YC0:
                begin
                    acc_reg   <= mres;
                    state_reg <= ST_YC1;
                end
                ST_YC1:
                begin
                    acc_reg   <= mres;
                    state_reg <= ST_YC2;
                end
                ST_YC2:
                begin
                    if (mres > OUT_MAX)
                        res_reg <= OUT_MAX[OUT_W-1:0];
                    else if (mres < OUT_MIN)
                        res_reg <= OUT_MIN[OUT_W-1:0];
                    else
                        res_reg <= mres[OUT_W-1:0];
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.eased_value = out_data_reg;

    `CBE_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
    `CBE_ASSERT_ALWAYS(a_div_only_in_wait, !drsp.busy || state_reg == ST_DIVW)
    `CBE_ASSERT_ALWAYS(a_step_bound, step_reg <= STEP_W'(NEWTON_STEPS))
    `CBE_ASSERT_NEXT(a_out_loads, state_reg == ST_OUT && out_free, out_ch.valid)
endmodule
`default_nettype wire
